// ===== design/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

    typedef logic [31:0] t_word;

    // One input transfer: a message byte and its qualifiers.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    // One output transfer: a digest word and its position.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } t_out_item;

    // Working variables of the compression.
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_work;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    localparam t_word SHA_IV0 = 32'h6745_2301;
    localparam t_word SHA_IV1 = 32'hEFCD_AB89;
    localparam t_word SHA_IV2 = 32'h98BA_DCFE;
    localparam t_word SHA_IV3 = 32'h1032_5476;
    localparam t_word SHA_IV4 = 32'hC3D2_E1F0;

    localparam t_word ROUND_K0 = 32'h5A82_7999;
    localparam t_word ROUND_K1 = 32'h6ED9_EBA1;
    localparam t_word ROUND_K2 = 32'h8F1B_BCDC;
    localparam t_word ROUND_K3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_MARK        = 8'h80;
    localparam logic [5:0] LAST_SHORT_FILL = 6'd55;
    localparam logic [5:0] LENGTH_START    = 6'd56;
    localparam logic [5:0] LAST_FILL       = 6'd63;
    localparam logic [6:0] LAST_ROUND      = 7'd79;
    localparam logic [2:0] LAST_WORD       = 3'd4;

endpackage

`default_nettype wire

// ===== design/sha1_round.sv =====
`default_nettype none

module sha1_round
    import sha1_pkg::*;
(
    input  t_work       i_work,
    input  t_word       i_w,
    input  logic [6:0]  i_round,
    output t_work       o_work
);

    t_word f_val;
    t_word k_val;

    always_comb begin
        priority if (i_round < 7'd20) begin
            f_val = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k_val = ROUND_K0;
        end else if (i_round < 7'd40) begin
            f_val = i_work.b ^ i_work.c ^ i_work.d;
            k_val = ROUND_K1;
        end else if (i_round < 7'd60) begin
            f_val = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k_val = ROUND_K2;
        end else begin
            f_val = i_work.b ^ i_work.c ^ i_work.d;
            k_val = ROUND_K3;
        end
    end

    always_comb begin
        o_work.a = {i_work.a[26:0], i_work.a[31:27]} + f_val + i_work.e + i_w + k_val;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

`default_nettype wire

// ===== design/sha1_byte_stream_hasher.sv =====
// SHA-1 hasher that absorbs a message one byte per input transfer and returns the
// 160-bit digest as five big-endian 32-bit words, word 0 first, the last flagged by
// final_word. A byte that does not complete a 64-byte block leaves the input ready
// for the next byte. The byte that completes a block is absorbed, then runs through
// the 80 rounds of the single shared round unit, and the result is folded into the
// chaining words. A closing transfer (end_of_message set, with or without a byte) is
// followed by padding laid in byte by byte up to the end of the block (64 minus the
// bytes pending, plus 64 more when over 55 bytes are pending), the compression of
// each padded block, then five output transfers. The input is not ready while a block
// is compressed, while padding is laid in, or while the digest is being delivered;
// after the last digest word the block starts afresh from the SHA-1 initial vector.
`default_nettype none

module sha1_byte_stream_hasher
    import sha1_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bit_count, n_bit_count;
    t_word       r_chain [5];
    t_word       n_chain [5];
    // The block buffer and the rolling message schedule share one 512-bit shift
    // line. Bytes enter at the bottom; during the rounds the top word is the
    // schedule word in use and each new schedule word enters at the bottom.
    logic [511:0] r_window, n_window;
    t_work       r_work, n_work;
    logic [6:0]  r_round, n_round;
    logic        r_padding, n_padding;
    logic        r_mark_done, n_mark_done;
    logic        r_len_block, n_len_block;
    logic [2:0]  r_word, n_word;

    t_work       round_work;
    t_word       sched_xor;
    t_word       sched_new;
    logic        push_en;
    logic [7:0]  push_byte;
    logic [7:0]  length_byte;
    logic [5:0]  length_shift;
    logic        in_xfer;
    logic        out_xfer;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;

    assign o_out_item.digest_word = r_chain[r_word];
    assign o_out_item.word_number = r_word;
    assign o_out_item.final_word  = (r_word == LAST_WORD);

    // Schedule taps W[t], W[t+2], W[t+8] and W[t+13] give W[t+16].
    assign sched_xor = r_window[511:480] ^ r_window[447:416] ^ r_window[255:224]
                     ^ r_window[95:64];
    assign sched_new = {sched_xor[30:0], sched_xor[31]};

    // Length bytes go out most significant first; position 56 carries bits 63..56.
    assign length_shift = {~r_fill[2:0], 3'b000};
    assign length_byte  = 8'(r_bit_count >> length_shift);

    sha1_round u_round (
        .i_work  (r_work),
        .i_w     (r_window[511:480]),
        .i_round (r_round),
        .o_work  (round_work)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bit_count = r_bit_count;
        n_chain     = r_chain;
        n_window    = r_window;
        n_work      = r_work;
        n_round     = r_round;
        n_padding   = r_padding;
        n_mark_done = r_mark_done;
        n_len_block = r_len_block;
        n_word      = r_word;
        push_en     = 1'b0;
        push_byte   = i_in_item.data_byte;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_item.has_byte) begin
                        push_en     = 1'b1;
                        n_bit_count = r_bit_count + 64'd8;
                    end
                    if (i_in_item.end_of_message) begin
                        n_padding   = 1'b1;
                        n_mark_done = 1'b0;
                        n_len_block = 1'b0;
                        n_state     = S_PAD;
                    end
                end
            end
            S_PAD: begin
                push_en = 1'b1;
                if (!r_mark_done) begin
                    push_byte   = PAD_MARK;
                    n_mark_done = 1'b1;
                    n_len_block = (r_fill <= LAST_SHORT_FILL);
                end else if (r_len_block && (r_fill >= LENGTH_START)) begin
                    push_byte = length_byte;
                end else begin
                    push_byte = 8'h00;
                end
            end
            S_ROUND: begin
                n_work   = round_work;
                n_window = {r_window[479:0], sched_new};
                n_round  = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_work.a;
                n_chain[1] = r_chain[1] + r_work.b;
                n_chain[2] = r_chain[2] + r_work.c;
                n_chain[3] = r_chain[3] + r_work.d;
                n_chain[4] = r_chain[4] + r_work.e;
                priority if (!r_padding) begin
                    n_state = S_IDLE;
                end else if (r_mark_done && r_len_block) begin
                    n_word  = 3'd0;
                    n_state = S_OUT;
                end else if (r_mark_done) begin
                    n_len_block = 1'b1;
                    n_state     = S_PAD;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (out_xfer) begin
                    if (r_word == LAST_WORD) begin
                        n_chain[0]  = SHA_IV0;
                        n_chain[1]  = SHA_IV1;
                        n_chain[2]  = SHA_IV2;
                        n_chain[3]  = SHA_IV3;
                        n_chain[4]  = SHA_IV4;
                        n_fill      = 6'd0;
                        n_bit_count = 64'd0;
                        n_padding   = 1'b0;
                        n_mark_done = 1'b0;
                        n_len_block = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        n_word = r_word + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The working variables are primed from the chaining words while bytes
        // are being gathered, so the rounds can start straight away.
        if ((r_state == S_IDLE) || (r_state == S_PAD)) begin
            n_work  = '{a: r_chain[0], b: r_chain[1], c: r_chain[2],
                        d: r_chain[3], e: r_chain[4]};
            n_round = 7'd0;
        end

        // A byte transfer into the block buffer; the last byte of a block
        // starts the compression, whatever state asked for it.
        if (push_en) begin
            n_window = {r_window[503:0], push_byte};
            n_fill   = r_fill + 6'd1;
            if (r_fill == LAST_FILL) begin
                n_state = S_ROUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 6'd0;
            r_bit_count <= 64'd0;
            r_chain[0]  <= SHA_IV0;
            r_chain[1]  <= SHA_IV1;
            r_chain[2]  <= SHA_IV2;
            r_chain[3]  <= SHA_IV3;
            r_chain[4]  <= SHA_IV4;
            r_round     <= 7'd0;
            r_padding   <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_block <= 1'b0;
            r_word      <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bit_count <= n_bit_count;
            r_chain     <= n_chain;
            r_round     <= n_round;
            r_padding   <= n_padding;
            r_mark_done <= n_mark_done;
            r_len_block <= n_len_block;
            r_word      <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
        r_work   <= n_work;
    end

`ifndef SYNTHESIS
    // The input side and the output side are never open together.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a digest word is offered");

    // The round counter never runs past the last round.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round <= LAST_ROUND))
        else $error("round counter out of range");

    // Delivering the final word leaves a fresh, empty message state.
    a_fresh_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out_item.final_word) |=>
            (o_in_ready && (r_fill == 6'd0) && (r_bit_count == 64'd0)))
        else $error("message state not cleared after digest");

    // Digest words are offered only when all three padding flags are set and the word number is in range.
    a_out_after_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_padding && r_mark_done && r_len_block && (r_word <= LAST_WORD)))
        else $error("digest offered before padding finished");
`endif

endmodule

`default_nettype wire
